// ===== rtl/core/pcr_pkg.sv =====
`default_nettype none

package pcr_pkg;

    localparam int MAX_POLY     = 16;
    localparam int VERTEX_W     = 32;
    localparam int IDX_W        = (MAX_POLY > 1) ? $clog2(MAX_POLY) : 1;
    localparam int CNT_W        = $clog2(MAX_POLY + 1);
    localparam int POS_W        = $clog2(2 * MAX_POLY + 1);
    localparam int RAM_AW       = IDX_W + 1;
    localparam int RAM_DEPTH    = 2 ** RAM_AW;
    localparam int NUM_BANKS    = 2;
    localparam int JOBQ_DEPTH   = 2;
    localparam int JOBQ_PW      = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CW      = $clog2(JOBQ_DEPTH + 1);
    localparam int OFF_FIELD_W  = 4;
    localparam int CNT_FIELD_W  = 5;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_index;
        logic                last_vertex;
    } t_item;

    typedef struct packed {
        logic [OFF_FIELD_W-1:0] rotation_offset;
        logic                   forward_direction;
        logic [CNT_FIELD_W-1:0] vertex_count;
        logic                   overflow;
    } t_result;

    // one finished polygon waiting for the scan unit
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } t_job;

    // scan unit releases a store bank
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

endpackage

`default_nettype wire

// ===== rtl/core/pcr_ram.sv =====
`default_nettype none

module pcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pcr_front.sv =====
`default_nettype none

module pcr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire pcr_pkg::t_item                i_item,
    output logic                               o_full,
    output logic                               o_we,
    output logic      [pcr_pkg::RAM_AW-1:0]    o_waddr,
    output logic      [pcr_pkg::VERTEX_W-1:0]  o_wdata,
    output logic                               o_job_push,
    output pcr_pkg::t_job                      o_job,
    input  wire logic                          i_job_full,
    input  wire pcr_pkg::t_done                i_done
);
    import pcr_pkg::*;

    logic             r_wbank;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_busy [NUM_BANKS];
    logic             accept;
    logic [CNT_W-1:0] n_count;
    logic             n_ovf;

    assign o_full  = r_busy[r_wbank] || i_job_full;
    assign accept  = i_push && !o_full;
    assign o_we    = accept && (r_count < CNT_W'(MAX_POLY));
    assign o_waddr = {r_wbank, IDX_W'(r_count)};
    assign o_wdata = i_item.vertex_index;
    assign n_count = r_count + CNT_W'(o_we);
    assign n_ovf   = r_ovf || (accept && !o_we);

    assign o_job_push = accept && i_item.last_vertex;
    assign o_job      = '{bank: r_wbank, count: n_count, ovf: n_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbank <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_busy[b] <= 1'b0;
            end
        end else begin
            if (i_done.valid) begin
                r_busy[i_done.bank] <= 1'b0;
            end
            if (o_job_push) begin
                r_busy[r_wbank] <= 1'b1;
                r_wbank         <= ~r_wbank;
                r_count         <= '0;
                r_ovf           <= 1'b0;
            end else if (accept) begin
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pcr_job_fifo.sv =====
`default_nettype none

module pcr_job_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pcr_pkg::t_job  i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output pcr_pkg::t_job       o_job,
    output logic                o_empty
);
    import pcr_pkg::*;

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_PW-1:0] r_wp;
    logic [JOBQ_PW-1:0] r_rp;
    logic [JOBQ_CW-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == JOBQ_CW'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == JOBQ_PW'(JOBQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == JOBQ_PW'(JOBQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + JOBQ_CW'(do_push) - JOBQ_CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pcr_back.sv =====
`default_nettype none

module pcr_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_consider_orient,
    input  wire pcr_pkg::t_job                 i_job,
    input  wire logic                          i_job_empty,
    output logic                               o_job_pop,
    output logic      [pcr_pkg::RAM_AW-1:0]    o_raddr_a,
    output logic      [pcr_pkg::RAM_AW-1:0]    o_raddr_b,
    input  wire logic [pcr_pkg::VERTEX_W-1:0]  i_rdata_a,
    input  wire logic [pcr_pkg::VERTEX_W-1:0]  i_rdata_b,
    output pcr_pkg::t_done                     o_done,
    output pcr_pkg::t_result                   o_result,
    output logic                               o_res_valid,
    input  wire logic                          i_res_pop
);
    import pcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_OUTER, ST_RD, ST_CMP, ST_ADV, ST_CRD, ST_CCMP, ST_OUT
    } t_state;

    t_state           r_state;
    logic             r_bank;
    logic             r_rev;
    logic             r_fwd;
    logic             r_ovf;
    logic [POS_W-1:0] r_n;
    logic [POS_W-1:0] r_i;
    logic [POS_W-1:0] r_j;
    logic [POS_W-1:0] r_k;
    logic [POS_W-1:0] r_best;
    logic [POS_W-1:0] r_off;
    logic [POS_W-1:0] r_back;
    t_result          r_result;
    logic             r_res_valid;
    logic             out_free;

    // position t of the forward or reversed cyclic sequence, t < 2n
    function automatic logic [IDX_W-1:0] seq_addr(input logic [POS_W-1:0] t,
                                                  input logic [POS_W-1:0] n,
                                                  input logic rev);
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] q;
        p = (t >= n) ? t - n : t;
        q = rev ? n - 1'b1 - p : p;
        return q[IDX_W-1:0];
    endfunction

    assign out_free    = !r_res_valid || i_res_pop;
    assign o_job_pop   = (r_state == ST_IDLE) && !i_job_empty;
    assign o_done      = '{valid: (r_state == ST_OUT) && out_free, bank: r_bank};
    assign o_result    = r_result;
    assign o_res_valid = r_res_valid;

    always_comb begin
        if (r_state == ST_CRD) begin
            o_raddr_a = {r_bank, seq_addr(r_off + r_k, r_n, 1'b0)};
            o_raddr_b = {r_bank, seq_addr(r_back + r_n - r_k, r_n, 1'b0)};
        end else begin
            o_raddr_a = {r_bank, seq_addr(r_k, r_n, r_rev)};
            o_raddr_b = {r_bank, seq_addr(r_j, r_n, r_rev)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && out_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        r_bank  <= i_job.bank;
                        r_n     <= POS_W'(i_job.count);
                        r_ovf   <= i_job.ovf;
                        r_rev   <= 1'b0;
                        r_i     <= '0;
                        r_fwd   <= 1'b1;
                        r_off   <= '0;
                        r_state <= i_job.ovf ? ST_OUT : ST_OUTER;
                    end
                end
                ST_OUTER: begin
                    if (r_i < r_n) begin
                        r_best  <= r_i;
                        r_j     <= r_i + 1'b1;
                        r_k     <= r_i;
                        r_state <= ST_RD;
                    end else if (!r_rev) begin
                        r_off <= r_best;
                        if (i_consider_orient) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_rev <= 1'b1;
                            r_i   <= '0;
                        end
                    end else begin
                        r_back  <= r_n - 1'b1 - r_best;
                        r_k     <= '0;
                        r_state <= ST_CRD;
                    end
                end
                ST_RD: begin
                    r_state <= (r_j < r_n + r_n) ? ST_CMP : ST_ADV;
                end
                ST_CMP: begin
                    if (i_rdata_a <= i_rdata_b) begin
                        r_k     <= (i_rdata_a < i_rdata_b) ? r_i : r_k + 1'b1;
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_RD;
                    end else begin
                        r_state <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    if (r_i <= r_k) begin
                        r_i <= r_i + (r_j - r_k);
                    end else begin
                        r_state <= ST_OUTER;
                    end
                end
                ST_CRD: begin
                    r_state <= (r_k < r_n) ? ST_CCMP : ST_OUT;
                end
                ST_CCMP: begin
                    if (i_rdata_a < i_rdata_b) begin
                        r_state <= ST_OUT;
                    end else if (i_rdata_a > i_rdata_b) begin
                        r_off   <= r_back;
                        r_fwd   <= 1'b0;
                        r_state <= ST_OUT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_CRD;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_result.rotation_offset   <= OFF_FIELD_W'(r_off);
                        r_result.forward_direction <= r_fwd;
                        r_result.vertex_count      <= CNT_FIELD_W'(r_n);
                        r_result.overflow          <= r_ovf;
                        r_state                    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_k < r_j))
        else $error("scan pointer k not behind j");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> (r_j <= r_n + r_n))
        else $error("scan pointer j past two laps");

    a_cmp_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRD || r_state == ST_CCMP) |-> (r_off < r_n && r_back < r_n))
        else $error("compare start outside polygon");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.valid |=> (r_state == ST_IDLE && r_res_valid))
        else $error("bank released without a result");

endmodule

`default_nettype wire

// ===== rtl/core/polygon_canonical_rotation_core.sv =====
// the front stores one vertex per cycle while o_full is low; after the last vertex the scan unit
//   runs each compare step as a registered store read, then a compare, and advances the start
//   between compare runs: a forward least-rotation scan, then, unless the option bit is set, a
//   backward scan and the reading compare; an overflowed polygon skips the scans
// the front loads the next polygon into the other bank while the scan unit works
// reset: synchronous active-low i_rst_n clears counts, bank flags, queues and the option bit
`default_nettype none

module polygon_canonical_rotation_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // vertex requests
    input  wire logic              i_push,
    input  wire pcr_pkg::t_item    i_item,
    output logic                   o_full,
    // result requests
    output logic                   o_empty,
    input  wire logic              i_pop,
    output pcr_pkg::t_result       o_result,
    // orientation option
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata
);
    import pcr_pkg::*;

    // 1 restricts the search to forward readings
    logic                r_consider_orient;

    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [VERTEX_W-1:0] ram_wdata;
    logic [RAM_AW-1:0]   ram_raddr_a;
    logic [RAM_AW-1:0]   ram_raddr_b;
    logic [VERTEX_W-1:0] ram_rdata_a;
    logic [VERTEX_W-1:0] ram_rdata_b;

    logic                job_push;
    logic                job_full;
    logic                job_pop;
    logic                job_empty;
    t_job                job_in;
    t_job                job_out;
    t_done               done;
    logic                res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_consider_orient <= 1'b0;
        end else if (i_cfg_we) begin
            r_consider_orient <= i_cfg_wdata;
        end
    end

    // front: counts vertices, flags overflow, fills one store bank per polygon
    pcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .o_full     (o_full),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full),
        .i_done     (done)
    );

    // two banks of vertex storage, bank bit on top of the address
    pcr_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // finished polygons waiting for the scan unit
    pcr_job_fifo u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    // back: forward least-rotation scan, then unless the option bit is set the backward scan and the reading compare
    pcr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_consider_orient (r_consider_orient),
        .i_job             (job_out),
        .i_job_empty       (job_empty),
        .o_job_pop         (job_pop),
        .o_raddr_a         (ram_raddr_a),
        .o_raddr_b         (ram_raddr_b),
        .i_rdata_a         (ram_rdata_a),
        .i_rdata_b         (ram_rdata_b),
        .o_done            (done),
        .o_result          (o_result),
        .o_res_valid       (res_valid),
        .i_res_pop         (i_pop)
    );

    assign o_empty = !res_valid;

endmodule

`default_nettype wire

// ===== test/tb_polygon_canonical_rotation_core.sv =====
`timescale 1ns / 100ps

module tb_polygon_canonical_rotation_core;

    import pcr_pkg::*;

    localparam int ITEMS_PER_PHASE = 255;   // random vertex requests per option setting
    localparam int NUM_PHASES      = 6;
    localparam int SETTLE_CYCLES   = 300;   // wait after draining so the scan unit goes quiet
    localparam int HOLD_AT         = 30;    // result count at which the receiver holds off
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_GAP         = 17;

    // value styles for random polygons
    localparam int STYLE_BINARY   = 0;
    localparam int STYLE_QUAD     = 1;
    localparam int STYLE_PERIODIC = 2;
    localparam int STYLE_EXTREME  = 3;
    localparam int STYLE_WIDE     = 4;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_push      = 1'b0;
    t_item   i_item      = '0;
    logic    i_pop       = 1'b0;
    logic    i_cfg_we    = 1'b0;
    logic    i_cfg_wdata = 1'b0;
    logic    o_full;
    logic    o_empty;
    t_result o_result;

    // one row of the directed script
    typedef struct {
        t_item   item;
        bit      typed;   // want is typed in by hand
        t_result want;
    } t_script_row;

    // shadow of the block: polygon being collected plus the option bit
    logic [VERTEX_W-1:0] poly_verts [MAX_POLY];
    int unsigned         poly_len     = 0;
    bit                  poly_spilled = 1'b0;
    bit                  orient_only  = 1'b0;

    t_result     rotation_q  [$];   // canonical readings still owed by the block
    t_script_row script_rows [$];
    int          mismatches  = 0;
    bit          rx_holding  = 1'b0;

    always #5 i_clk = ~i_clk;

    polygon_canonical_rotation_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    task automatic note_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %0d at %0t: %s got %0d want %0d", mismatches, $realtime, what,
                 got, want);
    endtask

    // element t of the cyclic forward or reversed reading
    function automatic logic [VERTEX_W-1:0] seq_vertex(input int unsigned t,
                                                       input int unsigned n, input bit rev);
        int unsigned p;
        p = t % n;
        return rev ? poly_verts[n-1-p] : poly_verts[p];
    endfunction

    // lyndon factorization scan, smallest start of the least rotation
    function automatic int unsigned least_start(input int unsigned n, input bit rev);
        int unsigned i;
        int unsigned j;
        int unsigned k;
        int unsigned best;
        i    = 0;
        best = 0;
        while (i < n) begin
            j    = i + 1;
            k    = i;
            best = i;
            while (j < 2 * n && seq_vertex(k, n, rev) <= seq_vertex(j, n, rev)) begin
                if (seq_vertex(k, n, rev) < seq_vertex(j, n, rev))
                    k = i;
                else
                    k++;
                j++;
            end
            while (i <= k)
                i += j - k;
        end
        return best;
    endfunction

    // absorb one vertex; on the last mark work out the canonical reading
    task automatic canon_vertex(input t_item it, output bit done, output t_result res);
        int unsigned         n;
        int unsigned         off;
        int unsigned         back;
        int                  order;
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
        done = 1'b0;
        res  = '0;
        if (poly_len < MAX_POLY) begin
            poly_verts[poly_len] = it.vertex_index;
            poly_len++;
        end else begin
            poly_spilled = 1'b1;
        end
        if (it.last_vertex) begin
            done = 1'b1;
            n    = poly_len;
            if (poly_spilled || n == 0) begin
                res.rotation_offset   = '0;
                res.forward_direction = 1'b1;
                res.vertex_count      = MAX_POLY[CNT_FIELD_W-1:0];
                res.overflow          = 1'b1;
            end else begin
                off = least_start(n, 1'b0);
                res.forward_direction = 1'b1;
                if (!orient_only) begin
                    // backward reading starts at n-1-m and walks down
                    back  = n - 1 - least_start(n, 1'b1);
                    order = 0;
                    for (int unsigned k = 0; k < n && order == 0; k++) begin
                        a = poly_verts[(off + k) % n];
                        b = poly_verts[(back + n - k) % n];
                        if (a < b)
                            order = -1;
                        else if (a > b)
                            order = 1;
                    end
                    // tie keeps the forward reading
                    if (order > 0) begin
                        off                   = back;
                        res.forward_direction = 1'b0;
                    end
                end
                res.rotation_offset = off[OFF_FIELD_W-1:0];
                res.vertex_count    = n[CNT_FIELD_W-1:0];
                res.overflow        = 1'b0;
            end
            poly_len     = 0;
            poly_spilled = 1'b0;
        end
    endtask

    // offer one vertex request after gap idle cycles; push is not lowered after acceptance
    // so that back-to-back requests keep it high
    task automatic push_vertex(input t_item it, input int gap, input bit typed,
                               input t_result want);
        bit      done;
        t_result res;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full !== 1'b0);
        canon_vertex(it, done, res);
        if (done)
            rotation_q.push_back(typed ? want : res);
    endtask

    // called right at an acceptance edge: stop offering, let every owed result out,
    // then give the scan unit time to go quiet
    task automatic drain_and_settle();
        i_push <= 1'b0;
        while (rotation_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_orientation(input bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        orient_only = value;
    endtask

    task automatic add_row(input logic [VERTEX_W-1:0] v, input bit last, input bit typed,
                           input t_result want);
        t_script_row row;
        row.item.vertex_index = v;
        row.item.last_vertex  = last;
        row.typed             = typed;
        row.want              = want;
        script_rows.push_back(row);
    endtask

    function automatic logic [VERTEX_W-1:0] draw_vertex(input int style);
        logic [VERTEX_W-1:0] v;
        case (style)
            STYLE_BINARY: v = VERTEX_W'($urandom_range(0, 1));
            STYLE_QUAD:   v = VERTEX_W'($urandom_range(0, 3));
            STYLE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = VERTEX_W'(1);
                    2:       v = {VERTEX_W{1'b1}} - 1'b1;
                    default: v = {VERTEX_W{1'b1}};
                endcase
            end
            default:      v = VERTEX_W'($urandom);
        endcase
        return v;
    endfunction

    // receiver: random pop gaps, calm stretches, and one long hold-off
    initial begin : result_drain
        int      gap;
        int      calm_left;
        int      popped;
        bit      hold;
        t_result got;
        t_result want;
        calm_left = 0;
        popped    = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = (popped == HOLD_AT);
            if (calm_left == 0 && $urandom_range(0, 7) == 0)
                calm_left = $urandom_range(1, 20);
            if (hold) begin
                gap = HOLD_CYCLES;
            end else if (calm_left > 0) begin
                gap = 0;
                calm_left--;
            end else begin
                gap = $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                i_pop      <= 1'b0;
                rx_holding = hold;
                repeat (gap) @(posedge i_clk);
                rx_holding = 1'b0;
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty !== 1'b0);
            got = o_result;
            popped++;
            if (rotation_q.size() == 0) begin
                note_mismatch("result with no polygon pending, offset", got.rotation_offset, 0);
            end else begin
                want = rotation_q.pop_front();
                if (got.rotation_offset !== want.rotation_offset)
                    note_mismatch("rotation_offset", got.rotation_offset,
                                  want.rotation_offset);
                if (got.forward_direction !== want.forward_direction)
                    note_mismatch("forward_direction", got.forward_direction,
                                  want.forward_direction);
                if (got.vertex_count !== want.vertex_count)
                    note_mismatch("vertex_count", got.vertex_count, want.vertex_count);
                if (got.overflow !== want.overflow)
                    note_mismatch("overflow", got.overflow, want.overflow);
            end
        end
    end

    initial begin : stimulus
        int                  sent;
        int                  size;
        int                  style;
        int                  period;
        int                  roll;
        int                  polys;
        bit                  calm;
        logic [VERTEX_W-1:0] pattern [4];
        t_item               it;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single vertex at both extremes
        add_row('0, 1'b1, 1'b1, {4'd0, 1'b1, 5'd1, 1'b0});
        add_row({VERTEX_W{1'b1}}, 1'b1, 1'b1, {4'd0, 1'b1, 5'd1, 1'b0});
        // backward reading strictly smaller than forward
        add_row(32'd1, 1'b0, 1'b0, '0);
        add_row(32'd3, 1'b0, 1'b0, '0);
        add_row(32'd2, 1'b1, 1'b0, '0);
        // forward and backward readings tie
        add_row({VERTEX_W{1'b1}}, 1'b0, 1'b0, '0);
        add_row('0, 1'b1, 1'b0, '0);
        // one vertex past capacity
        for (int v = 0; v <= MAX_POLY; v++)
            add_row(VERTEX_W'(v * 32'h0F0F_0F0F), v == MAX_POLY, v == MAX_POLY,
                    {4'd0, 1'b1, 5'd16, 1'b1});

        // directed part runs with the option at its reset value
        foreach (script_rows[r])
            push_vertex(script_rows[r].item, $urandom_range(0, MAX_GAP), script_rows[r].typed,
                        script_rows[r].want);
        drain_and_settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_orientation(phase % 2 == 0);
            sent  = 0;
            polys = 0;
            while (sent < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    size = $urandom_range(MAX_POLY + 1, MAX_POLY + 4);
                else if (roll < 15)
                    size = MAX_POLY;
                else if (roll < 55)
                    size = $urandom_range(1, 5);
                else
                    size = $urandom_range(1, MAX_POLY);
                style  = $urandom_range(STYLE_BINARY, STYLE_WIDE);
                period = $urandom_range(1, 4);
                foreach (pattern[p])
                    pattern[p] = draw_vertex($urandom_range(0, 1) ? STYLE_QUAD : STYLE_WIDE);
                calm = ($urandom_range(0, 3) == 0);
                for (int v = 0; v < size; v++) begin
                    it.vertex_index = (style == STYLE_PERIODIC) ? pattern[v % period]
                                                                : draw_vertex(style);
                    it.last_vertex  = (v == size - 1);
                    push_vertex(it, (calm || rx_holding) ? 0 : $urandom_range(0, MAX_GAP),
                                1'b0, '0);
                end
                sent += size;
                polys++;
                // sender waits once for the block to empty out completely
                if (phase == 2 && polys == 10) begin
                    i_push <= 1'b0;
                    while (rotation_q.size() != 0) @(posedge i_clk);
                end
            end
            drain_and_settle();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
